@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the fan tachometer block.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ rtl/core/fts_pkg.sv @@
// Types and constants for the fan tachometer RPM smoother.
// Used by fan_tacho_rpm_smoother; depends on nothing.
package fts_pkg;

	// Microseconds per minute, the RPM scale factor.
	localparam logic [25:0] RPM_SCALE = 26'd60000000;

	// Numerator is a non-negative 15-bit count times the scale.
	localparam int NUM_W = 41;
	// Denominator is a 32-bit elapsed time times a 4-bit pulse ratio.
	localparam int DEN_W = 36;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PPR = 2'd2;

	localparam logic [15:0] ALPHA_RST = 16'd2947;
	localparam logic [23:0] INTERVAL_RST = 24'd1000000;
	localparam logic [3:0] PPR_RST = 4'd2;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_SM_CHK,
		ST_SM_MUL,
		ST_SM_STEP,
		ST_SM_APPLY,
		ST_FIN
	} state_t;

endpackage

@@ rtl/core/fts_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Uses no package; instantiated by fan_tacho_rpm_smoother.
module fts_div #(
	parameter int NUM_W = 41,
	parameter int DEN_W = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] q_q;
	logic [DEN_W-1:0] d_q;
	logic [DEN_W-1:0] r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   trial_sub;
	logic             fits;

	// The partial remainder stays below the divisor, so the shifted value fits DEN_W+1 bits.
	always_comb begin
		trial = {r_q, q_q[NUM_W-1]};
		fits = trial >= {1'b0, d_q};
		trial_sub = trial - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			d_q <= den;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[NUM_W-2:0], fits};
			r_q <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

@@ rtl/core/fan_tacho_rpm_smoother.sv @@
// Fan tachometer RPM measurement with exponential smoothing of the result.
// A start request goes to ST_FIN and then to the output registers once they are free; a tick
// runs ST_TICK, then the 41-step divider (ST_MUL, ST_DIV_GO, ST_DIV_WAIT) only when it measures,
// then the smoothing states. One request is in work at a time.
// Reset (arst_n, asynchronous, active low) clears the time, count and RPM state and
// loads the register defaults: alpha 2947, interval 1000000 us, 2 pulses per rev.
`include "assert_macros.svh"

module fan_tacho_rpm_smoother #(
	parameter int RPM_BITS = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         command,
	input  logic [31:0]                  now_us,
	input  logic signed [15:0]           pulse_count,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [RPM_BITS-1:0]          smooth_rpm,
	output logic [RPM_BITS-1:0]          raw_rpm,
	output logic                         clear_counter,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [fts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fts_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int SMW = RPM_BITS + 16;
	localparam logic [RPM_BITS-1:0] RPM_MAX = '1;

	fts_pkg::state_t state_q, state_d;

	logic [15:0]         alpha_q;
	logic [23:0]         interval_q;
	logic [3:0]          ppr_q;

	logic [31:0]         last_time_q;
	logic signed [15:0]  last_pulses_q;
	logic [RPM_BITS-1:0] measured_q;
	logic [SMW-1:0]      smooth_q;

	logic                cmd_q;
	logic [31:0]         now_q;
	logic signed [15:0]  count_q;
	logic [31:0]         dt_q;
	logic                clr_q;

	logic [fts_pkg::NUM_W-1:0] num_q;
	logic [fts_pkg::DEN_W-1:0] den_q;

	logic [SMW-1:0]      diff_q;
	logic                up_q;
	logic [SMW-1:0]      p_hi_q;
	logic [31:0]         p_lo_q;
	logic [SMW-1:0]      step_q;

	logic [RPM_BITS-1:0] out_smooth_q;
	logic [RPM_BITS-1:0] out_raw_q;
	logic                out_clr_q;
	logic                out_valid_q;

	logic                in_acc;
	logic                out_free;
	logic                div_start;
	logic                div_done;
	logic                load_out;
	logic [fts_pkg::NUM_W-1:0] div_quot;

	logic [31:0]         elapsed;
	logic                do_measure;
	logic                is_dup;
	logic [3:0]          ppr_eff;
	logic [SMW-1:0]      target;
	logic [SMW:0]        step_sum;
	logic [SMW:0]        step_lim;
	logic [SMW-1:0]      smooth_nxt;
	logic [RPM_BITS-1:0] rpm_sat;

	fts_div #(
		.NUM_W(fts_pkg::NUM_W),
		.DEN_W(fts_pkg::DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num_q),
		.den   (den_q),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign in_acc = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;

	always_comb begin
		elapsed = now_q - last_time_q;
		do_measure = elapsed > {8'd0, interval_q};
		// Count exactly one below the previous sample: keep the RPM, refresh only the time.
		is_dup = ({last_pulses_q[15], last_pulses_q} - 17'sd1) == {count_q[15], count_q};
		ppr_eff = (ppr_q == 4'd0) ? 4'd1 : ppr_q;
		target = {measured_q, 16'd0};
		step_sum = (SMW+1)'(p_hi_q) + (SMW+1)'(p_lo_q[31:16]);
		if (step_sum == '0) begin
			step_sum = (SMW+1)'(1);
		end
		step_lim = (step_sum > {1'b0, diff_q}) ? {1'b0, diff_q} : step_sum;
		smooth_nxt = up_q ? (smooth_q + step_q) : (smooth_q - step_q);
		if (div_quot[fts_pkg::NUM_W-1:RPM_BITS] != '0) begin
			rpm_sat = RPM_MAX;
		end else begin
			rpm_sat = div_quot[RPM_BITS-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fts_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = (command == fts_pkg::CMD_TICK) ? fts_pkg::ST_TICK : fts_pkg::ST_FIN;
				end
			end
			fts_pkg::ST_TICK: begin
				if (!do_measure || count_q[15] || is_dup) begin
					state_d = fts_pkg::ST_SM_CHK;
				end else begin
					state_d = fts_pkg::ST_MUL;
				end
			end
			fts_pkg::ST_MUL:      state_d = fts_pkg::ST_DIV_GO;
			fts_pkg::ST_DIV_GO:   state_d = fts_pkg::ST_DIV_WAIT;
			fts_pkg::ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = fts_pkg::ST_SM_CHK;
				end
			end
			fts_pkg::ST_SM_CHK: begin
				if (smooth_q[SMW-1:16] == measured_q) begin
					state_d = fts_pkg::ST_FIN;
				end else begin
					state_d = fts_pkg::ST_SM_MUL;
				end
			end
			fts_pkg::ST_SM_MUL:   state_d = fts_pkg::ST_SM_STEP;
			fts_pkg::ST_SM_STEP:  state_d = fts_pkg::ST_SM_APPLY;
			fts_pkg::ST_SM_APPLY: state_d = fts_pkg::ST_FIN;
			fts_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = fts_pkg::ST_IDLE;
				end
			end
			default: state_d = fts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		div_start = 1'b0;
		load_out = 1'b0;
		case (state_q)
			fts_pkg::ST_IDLE:   in_ready = 1'b1;
			fts_pkg::ST_DIV_GO: div_start = 1'b1;
			fts_pkg::ST_FIN:    load_out = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fts_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			alpha_q <= fts_pkg::ALPHA_RST;
			interval_q <= fts_pkg::INTERVAL_RST;
			ppr_q <= fts_pkg::PPR_RST;
			last_time_q <= '0;
			last_pulses_q <= '0;
			measured_q <= '0;
			smooth_q <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fts_pkg::CFG_ALPHA:    alpha_q <= cfg_data[15:0];
					fts_pkg::CFG_INTERVAL: interval_q <= cfg_data[23:0];
					fts_pkg::CFG_PPR:      ppr_q <= cfg_data[3:0];
					default: begin
					end
				endcase
			end

			case (state_q)
				fts_pkg::ST_IDLE: begin
					if (in_acc && command == fts_pkg::CMD_START) begin
						last_time_q <= now_us;
					end
				end
				fts_pkg::ST_TICK: begin
					if (do_measure) begin
						if (count_q[15]) begin
							measured_q <= '0;
							last_pulses_q <= '0;
							last_time_q <= now_q;
						end else if (is_dup) begin
							last_time_q <= now_q;
						end
					end
				end
				fts_pkg::ST_DIV_WAIT: begin
					if (div_done) begin
						measured_q <= rpm_sat;
						last_time_q <= now_q;
						last_pulses_q <= count_q;
					end
				end
				fts_pkg::ST_SM_APPLY: begin
					// Snap to the raw value once the integer part arrives there.
					if (smooth_nxt[SMW-1:16] == measured_q) begin
						smooth_q <= target;
					end else begin
						smooth_q <= smooth_nxt;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fts_pkg::ST_IDLE: begin
				if (in_acc) begin
					cmd_q <= command;
					now_q <= now_us;
					count_q <= pulse_count;
					clr_q <= 1'b0;
				end
			end
			fts_pkg::ST_TICK: begin
				clr_q <= do_measure;
				dt_q <= elapsed;
			end
			fts_pkg::ST_MUL: begin
				num_q <= fts_pkg::NUM_W'(count_q[14:0]) * fts_pkg::NUM_W'(fts_pkg::RPM_SCALE);
				den_q <= fts_pkg::DEN_W'(dt_q) * fts_pkg::DEN_W'(ppr_eff);
			end
			fts_pkg::ST_SM_CHK: begin
				up_q <= target > smooth_q;
				diff_q <= (target > smooth_q) ? (target - smooth_q) : (smooth_q - target);
			end
			fts_pkg::ST_SM_MUL: begin
				p_hi_q <= SMW'(diff_q[SMW-1:16]) * SMW'(alpha_q);
				p_lo_q <= 32'(diff_q[15:0]) * 32'(alpha_q);
			end
			fts_pkg::ST_SM_STEP: begin
				step_q <= step_lim[SMW-1:0];
			end
			fts_pkg::ST_FIN: begin
				if (load_out) begin
					out_smooth_q <= smooth_q[SMW-1:16];
					out_raw_q <= measured_q;
					out_clr_q <= clr_q && (cmd_q == fts_pkg::CMD_TICK);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign smooth_rpm = out_smooth_q;
	assign raw_rpm = out_raw_q;
	assign clear_counter = out_clr_q;

	`ASSERT_CLK(a_one_request, clk, arst_n, in_acc |=> !in_ready)
	`ASSERT_NEVER(a_div_done_out_of_place, clk, arst_n, div_done && (state_q != fts_pkg::ST_DIV_WAIT))
	`ASSERT_CLK(a_snap_fraction, clk, arst_n, (state_q == fts_pkg::ST_SM_APPLY) |=> ((smooth_q[SMW-1:16] != measured_q) || (smooth_q[15:0] == 16'd0)))

endmodule
